@@ rtl/linear_value_animator_core_assert.svh @@
// assertion macros for the linear value animator
// clocked on clk_i, disabled while rst_ni is low
`ifndef LINEAR_VALUE_ANIMATOR_CORE_ASSERT_SVH
`define LINEAR_VALUE_ANIMATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LVA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lva assertion failed");
`define LVA_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("lva forbidden condition seen");
`else
`define LVA_ASSERT(lbl, prop)
`define LVA_NEVER(lbl, expr)
`endif
`endif

@@ rtl/lva_pkg.sv @@
// shared widths, codes, state enums and structs of the linear value animator
// no dependencies
package lva_pkg;

  localparam int VALUE_BITS    = 16;
  localparam int TIME_BITS     = 24;
  localparam int ADV_BITS      = 16;
  localparam int REP_BITS      = 16;
  localparam int MODE_BITS     = 2;
  localparam int REQ_BITS      = 2;
  localparam int CNT_BITS      = $clog2(VALUE_BITS);
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 5;
  localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

  typedef logic [MODE_BITS-1:0]    mode_t;
  typedef logic [REQ_BITS-1:0]     req_t;
  typedef logic [REG_IDX_BITS-1:0] reg_idx_t;

  localparam mode_t MODE_NONE     = 2'd0;
  localparam mode_t MODE_RAMP     = 2'd1;
  localparam mode_t MODE_PINGPONG = 2'd2;

  localparam req_t REQ_TICK  = 2'd0;
  localparam req_t REQ_START = 2'd1;
  localparam req_t REQ_SET   = 2'd2;

  localparam reg_idx_t REG_MODE     = 3'd0;
  localparam reg_idx_t REG_BEGIN    = 3'd1;
  localparam reg_idx_t REG_END      = 3'd2;
  localparam reg_idx_t REG_DELAY    = 3'd3;
  localparam reg_idx_t REG_PHASE    = 3'd4;
  localparam reg_idx_t REG_DURATION = 3'd5;
  localparam reg_idx_t REG_REPEAT   = 3'd6;

  localparam logic [REP_BITS-1:0] REPEAT_FOREVER = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DCHK,
    S_RCHK,
    S_LERP,
    S_DONE
  } ctrl_state_e;

  typedef enum logic [1:0] {
    L_IDLE,
    L_MUL,
    L_DIV,
    L_RND
  } lerp_state_e;

  typedef struct packed {
    logic                  start;
    logic [TIME_BITS-1:0]  num;
    logic [VALUE_BITS-1:0] span;
    logic [TIME_BITS-1:0]  den;
    logic [VALUE_BITS-1:0] base;
  } lerp_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] value;
  } lerp_rsp_t;

endpackage

@@ rtl/lva_if.sv @@
// valid/ready channels of the linear value animator: request and result words
// depends on lva_pkg
interface lva_req_if;
  import lva_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REQ_BITS-1:0]   req_type;
  logic [ADV_BITS-1:0]   advance_ms;
  logic [VALUE_BITS-1:0] new_value;
  modport source (output valid, req_type, advance_ms, new_value, input ready);
  modport sink (input valid, req_type, advance_ms, new_value, output ready);
endinterface

interface lva_rsp_if;
  import lva_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] current_value;
  logic                  pending;
  logic                  holding_delay;
  modport source (output valid, current_value, pending, holding_delay, input ready);
  modport sink (input valid, current_value, pending, holding_delay, output ready);
endinterface

@@ rtl/lva_lerp.sv @@
// shared interpolation unit: base + round(num * span / den), ties rounded down
// one multiply, then a restoring divide one quotient bit a cycle; depends on lva_pkg
`include "linear_value_animator_core_assert.svh"

module lva_lerp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lva_pkg::lerp_req_t req_i,
  output lva_pkg::lerp_rsp_t rsp_o
);
  import lva_pkg::*;

  lerp_state_e state_q, state_d;

  logic [TIME_BITS-1:0]  num_q;
  logic [VALUE_BITS-1:0] span_q;
  logic [TIME_BITS-1:0]  den_q;
  logic [VALUE_BITS-1:0] base_q;
  logic [TIME_BITS-1:0]  rem_q;
  logic [VALUE_BITS-1:0] quo_q;
  logic [CNT_BITS-1:0]   cnt_q;

  logic [TIME_BITS:0]    shifted;
  logic [TIME_BITS:0]    den_ext;
  logic [TIME_BITS:0]    diff;
  logic                  fits;
  logic                  round_up;

  assign shifted  = {rem_q, quo_q[VALUE_BITS-1]};
  assign den_ext  = {1'b0, den_q};
  assign fits     = shifted >= den_ext;
  assign diff     = shifted - den_ext;
  assign round_up = {rem_q, 1'b0} > den_ext;

  assign rsp_o.done  = state_q == L_RND;
  assign rsp_o.value = base_q + quo_q + {{(VALUE_BITS-1){1'b0}}, round_up};

  always_comb begin
    state_d = state_q;
    case (state_q)
      L_IDLE: begin
        if (req_i.start) state_d = L_MUL;
      end
      L_MUL: state_d = L_DIV;
      L_DIV: begin
        if (cnt_q == CNT_BITS'(VALUE_BITS - 1)) state_d = L_RND;
      end
      L_RND: state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: begin
        if (req_i.start) begin
          num_q  <= req_i.num;
          span_q <= req_i.span;
          den_q  <= req_i.den;
          base_q <= req_i.base;
        end
      end
      L_MUL: begin
        {rem_q, quo_q} <= num_q * span_q;
        cnt_q          <= '0;
      end
      L_DIV: begin
        rem_q <= fits ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
        quo_q <= {quo_q[VALUE_BITS-2:0], fits};
        cnt_q <= cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  `LVA_ASSERT(a_start_when_idle, req_i.start |-> state_q == L_IDLE)
  `LVA_ASSERT(a_mul_then_div, state_q == L_MUL |=> (state_q == L_DIV && cnt_q == '0))
  `LVA_ASSERT(a_rem_below_den, (state_q == L_DIV || state_q == L_RND) |-> rem_q < den_q)
  `LVA_NEVER(a_zero_divisor, state_q == L_DIV && den_q == '0)

endmodule

@@ rtl/linear_value_animator_core.sv @@
// linear value animator top level: apb registers, request sequencer, output register
// depends on lva_pkg, lva_if and lva_lerp
// start, set and idle ticks: S_EXEC then S_DONE; delay and end ticks also pass S_DCHK or S_RCHK
// ramp ticks also wait in S_LERP for the 16-step divide in the shared lerp unit
// one word at a time: next word accepted once the result sits in the output register
// async reset clears config, animation state and valid flags; no clearing pass
`include "linear_value_animator_core_assert.svh"

module linear_value_animator_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lva_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [lva_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [lva_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready,
  lva_req_if.sink                            req_i,
  lva_rsp_if.source                          rsp_o
);
  import lva_pkg::*;

  // configuration registers
  mode_t                 cfg_mode_q;
  logic [VALUE_BITS-1:0] cfg_begin_q;
  logic [VALUE_BITS-1:0] cfg_end_q;
  logic [TIME_BITS-1:0]  cfg_delay_q;
  logic [TIME_BITS-1:0]  cfg_phase_q;
  logic [TIME_BITS-1:0]  cfg_dur_q;
  logic [REP_BITS-1:0]   cfg_rep_q;
  reg_idx_t              reg_idx;
  logic                  cfg_wr;

  // latched request word
  req_t                  req_q;
  logic [ADV_BITS-1:0]   adv_q;
  logic [VALUE_BITS-1:0] newv_q;

  // animation state
  ctrl_state_e           state_q, state_d;
  mode_t                 run_mode_q, run_mode_d;
  logic                  in_delay_q, in_delay_d;
  logic                  in_ramp_q, in_ramp_d;
  logic [TIME_BITS-1:0]  delay_el_q, delay_el_d;
  logic [TIME_BITS-1:0]  run_el_q, run_el_d;
  logic [REP_BITS-1:0]   repeats_q, repeats_d;
  logic [TIME_BITS-1:0]  run_dur_q, run_dur_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic [VALUE_BITS-1:0] v_begin_q, v_begin_d;
  logic [VALUE_BITS-1:0] v_end_q, v_end_d;
  logic [TIME_BITS-1:0]  t_delay_q, t_delay_d;
  logic [TIME_BITS-1:0]  t_phase_q, t_phase_d;
  logic                  up_q, up_d;
  logic [VALUE_BITS-1:0] span_q, span_d;
  logic [TIME_BITS-1:0]  back_q, back_d;

  // output register
  logic                  out_valid_q;
  logic                  out_load;
  logic [VALUE_BITS-1:0] out_value_q;
  logic                  out_pend_q;
  logic                  out_hold_q;

  logic [TIME_BITS:0]    dsum;
  logic [TIME_BITS:0]    rsum;
  logic [TIME_BITS-1:0]  dsat;
  logic [TIME_BITS-1:0]  rsat;
  logic                  ph_gt_du;
  logic                  e_gt_b;
  logic                  degenerate;
  logic [TIME_BITS-1:0]  ramp_num;
  logic [TIME_BITS-1:0]  back_num;
  logic                  req_fire;

  lerp_req_t             lerp_req;
  lerp_rsp_t             lerp_rsp;

  // apb port
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_BITS-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      REG_MODE:     prdata = APB_DATA_BITS'(cfg_mode_q);
      REG_BEGIN:    prdata = APB_DATA_BITS'(cfg_begin_q);
      REG_END:      prdata = APB_DATA_BITS'(cfg_end_q);
      REG_DELAY:    prdata = APB_DATA_BITS'(cfg_delay_q);
      REG_PHASE:    prdata = APB_DATA_BITS'(cfg_phase_q);
      REG_DURATION: prdata = APB_DATA_BITS'(cfg_dur_q);
      REG_REPEAT:   prdata = APB_DATA_BITS'(cfg_rep_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mode_q  <= MODE_NONE;
      cfg_begin_q <= '0;
      cfg_end_q   <= '0;
      cfg_delay_q <= '0;
      cfg_phase_q <= '0;
      cfg_dur_q   <= '0;
      cfg_rep_q   <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MODE:     cfg_mode_q  <= pwdata[MODE_BITS-1:0];
        REG_BEGIN:    cfg_begin_q <= pwdata[VALUE_BITS-1:0];
        REG_END:      cfg_end_q   <= pwdata[VALUE_BITS-1:0];
        REG_DELAY:    cfg_delay_q <= pwdata[TIME_BITS-1:0];
        REG_PHASE:    cfg_phase_q <= pwdata[TIME_BITS-1:0];
        REG_DURATION: cfg_dur_q   <= pwdata[TIME_BITS-1:0];
        REG_REPEAT:   cfg_rep_q   <= pwdata[REP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // request channel
  assign req_i.ready = state_q == S_IDLE;
  assign req_fire    = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q  <= req_i.req_type;
      adv_q  <= req_i.advance_ms;
      newv_q <= req_i.new_value;
    end
  end

  // saturating elapsed counters
  assign dsum = {1'b0, delay_el_q} + (TIME_BITS + 1)'(adv_q);
  assign rsum = {1'b0, run_el_q} + (TIME_BITS + 1)'(adv_q);
  assign dsat = dsum[TIME_BITS] ? '1 : dsum[TIME_BITS-1:0];
  assign rsat = rsum[TIME_BITS] ? '1 : rsum[TIME_BITS-1:0];

  assign ph_gt_du   = cfg_phase_q > cfg_dur_q;
  assign e_gt_b     = cfg_end_q > cfg_begin_q;
  assign degenerate = !(cfg_mode_q == MODE_RAMP || cfg_mode_q == MODE_PINGPONG)
                      || (cfg_phase_q == '0 && cfg_dur_q == '0)
                      || cfg_begin_q == cfg_end_q;

  assign ramp_num = up_q ? run_el_q : t_phase_q - run_el_q;
  assign back_num = up_q ? run_dur_q - run_el_q : run_el_q - t_phase_q;

  always_comb begin
    state_d    = state_q;
    run_mode_d = run_mode_q;
    in_delay_d = in_delay_q;
    in_ramp_d  = in_ramp_q;
    delay_el_d = delay_el_q;
    run_el_d   = run_el_q;
    repeats_d  = repeats_q;
    run_dur_d  = run_dur_q;
    value_d    = value_q;
    v_begin_d  = v_begin_q;
    v_end_d    = v_end_q;
    t_delay_d  = t_delay_q;
    t_phase_d  = t_phase_q;
    up_d       = up_q;
    span_d     = span_q;
    back_d     = back_q;
    out_load   = 1'b0;

    lerp_req.start = 1'b0;
    lerp_req.num   = ramp_num;
    lerp_req.span  = span_q;
    lerp_req.den   = t_phase_q;
    lerp_req.base  = up_q ? v_begin_q : v_end_q;

    case (state_q)
      S_IDLE: begin
        if (req_fire) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (req_q)
          REQ_TICK: begin
            if (run_mode_q != MODE_NONE) begin
              if (in_delay_q) begin
                delay_el_d = dsat;
                state_d    = S_DCHK;
              end else begin
                run_el_d = rsat;
                state_d  = S_RCHK;
              end
            end
          end
          REQ_START: begin
            in_delay_d = 1'b0;
            in_ramp_d  = 1'b0;
            delay_el_d = '0;
            run_el_d   = '0;
            if (degenerate) begin
              run_mode_d = MODE_NONE;
              value_d    = cfg_end_q;
            end else begin
              run_mode_d = cfg_mode_q;
              v_begin_d  = cfg_begin_q;
              v_end_d    = cfg_end_q;
              t_delay_d  = cfg_delay_q;
              t_phase_d  = cfg_phase_q;
              run_dur_d  = ph_gt_du ? cfg_phase_q : cfg_dur_q;
              repeats_d  = cfg_rep_q;
              up_d       = e_gt_b;
              span_d     = e_gt_b ? cfg_end_q - cfg_begin_q : cfg_begin_q - cfg_end_q;
              back_d     = ph_gt_du ? '0 : cfg_dur_q - cfg_phase_q;
              in_ramp_d  = cfg_phase_q != '0;
              value_d    = (cfg_phase_q != '0) ? cfg_begin_q : cfg_end_q;
              if (cfg_delay_q != '0) begin
                in_delay_d = 1'b1;
                in_ramp_d  = 1'b0;
              end
            end
          end
          REQ_SET: begin
            run_mode_d = MODE_NONE;
            in_delay_d = 1'b0;
            in_ramp_d  = 1'b0;
            value_d    = newv_q;
          end
          default: ;
        endcase
      end
      S_DCHK: begin
        if (delay_el_q < t_delay_q) begin
          state_d = S_DONE;
        end else begin
          in_delay_d = 1'b0;
          run_el_d   = '0;
          in_ramp_d  = t_phase_q != '0;
          value_d    = (t_phase_q != '0) ? v_begin_q : v_end_q;
          state_d    = S_RCHK;
        end
      end
      S_RCHK: begin
        state_d = S_DONE;
        if (run_el_q >= run_dur_q) begin
          value_d = (run_mode_q == MODE_PINGPONG && back_q != '0) ? v_begin_q : v_end_q;
          if (repeats_q == '0) begin
            run_mode_d = MODE_NONE;
          end else begin
            if (repeats_q != REPEAT_FOREVER) repeats_d = repeats_q - 1'b1;
            in_delay_d = 1'b0;
            run_el_d   = '0;
            in_ramp_d  = t_phase_q != '0;
            value_d    = (t_phase_q != '0) ? v_begin_q : v_end_q;
          end
        end else if (in_ramp_q) begin
          if (run_el_q >= t_phase_q) begin
            in_ramp_d = 1'b0;
            value_d   = v_end_q;
          end else begin
            lerp_req.start = 1'b1;
            state_d        = S_LERP;
          end
        end else if (run_mode_q == MODE_PINGPONG && run_el_q >= t_phase_q
                     && back_q != '0) begin
          lerp_req.start = 1'b1;
          lerp_req.num   = back_num;
          lerp_req.den   = back_q;
          state_d        = S_LERP;
        end
      end
      S_LERP: begin
        if (lerp_rsp.done) begin
          value_d = lerp_rsp.value;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      run_mode_q <= MODE_NONE;
      in_delay_q <= 1'b0;
      in_ramp_q  <= 1'b0;
      delay_el_q <= '0;
      run_el_q   <= '0;
      repeats_q  <= '0;
      run_dur_q  <= '0;
      value_q    <= '0;
      v_begin_q  <= '0;
      v_end_q    <= '0;
      t_delay_q  <= '0;
      t_phase_q  <= '0;
      up_q       <= 1'b0;
      span_q     <= '0;
      back_q     <= '0;
    end else begin
      state_q    <= state_d;
      run_mode_q <= run_mode_d;
      in_delay_q <= in_delay_d;
      in_ramp_q  <= in_ramp_d;
      delay_el_q <= delay_el_d;
      run_el_q   <= run_el_d;
      repeats_q  <= repeats_d;
      run_dur_q  <= run_dur_d;
      value_q    <= value_d;
      v_begin_q  <= v_begin_d;
      v_end_q    <= v_end_d;
      t_delay_q  <= t_delay_d;
      t_phase_q  <= t_phase_d;
      up_q       <= up_d;
      span_q     <= span_d;
      back_q     <= back_d;
    end
  end

  lva_lerp u_lerp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lerp_req),
    .rsp_o  (lerp_rsp)
  );

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= value_q;
      out_pend_q  <= run_mode_q != MODE_NONE;
      out_hold_q  <= (run_mode_q != MODE_NONE) && in_delay_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.current_value = out_value_q;
  assign rsp_o.pending       = out_pend_q;
  assign rsp_o.holding_delay = out_hold_q;

  `LVA_ASSERT(a_delay_needs_run, in_delay_q |-> run_mode_q != MODE_NONE)
  `LVA_NEVER(a_delay_and_ramp, in_delay_q && in_ramp_q)
  `LVA_ASSERT(a_lerp_done_awaited, lerp_rsp.done |-> state_q == S_LERP)
  `LVA_ASSERT(a_accept_to_exec, req_fire |=> state_q == S_EXEC)
  `LVA_ASSERT(a_hold_implies_pend, rsp_o.valid |-> (rsp_o.pending || !rsp_o.holding_delay))

endmodule

@@ tb/tb_linear_value_animator_core.sv @@
// self-checking testbench for linear_value_animator_core: apb config, request and result words
// predicts every result word in place and compares it field by field as it is accepted
// depends on lva_pkg, lva_if and the core rtl
module tb_linear_value_animator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lva_pkg::*;

  localparam req_t  REQ_UNUSED      = 2'd3;
  localparam mode_t MODE_UNUSED     = 2'd3;
  localparam int    RESET_CYCLES    = 11;
  localparam int    SETTLE_CYCLES   = 60;
  localparam int    WATCHDOG_CYCLES = 2000;
  localparam int    HOLD_CYCLES     = 300;
  localparam int    RANDOM_PHASES   = 5;
  localparam int    WORDS_PER_PHASE = 19;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  pending;
    logic                  holding;
  } frame_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  lva_req_if req_ch ();
  lva_rsp_if rsp_ch ();

  linear_value_animator_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // animation state as the block should hold it
  logic [APB_DATA_BITS-1:0] cfg_q [7] = '{default: '0};
  mode_t                    an_mode      = MODE_NONE;
  logic                     an_delaying  = 1'b0;
  logic                     an_ramping   = 1'b0;
  logic [TIME_BITS-1:0]     an_delay_acc = '0;
  logic [TIME_BITS-1:0]     an_run_ms    = '0;
  logic [TIME_BITS-1:0]     an_run_len   = '0;
  logic [TIME_BITS-1:0]     an_hold_ms   = '0;
  logic [TIME_BITS-1:0]     an_ramp_ms   = '0;
  logic [REP_BITS-1:0]      an_repeats   = '0;
  logic [VALUE_BITS-1:0]    an_value     = '0;
  logic [VALUE_BITS-1:0]    an_from      = '0;
  logic [VALUE_BITS-1:0]    an_to        = '0;

  frame_t due_frames [$];
  frame_t want;
  int     errors          = 0;
  int     n_checked       = 0;
  int     n_ticks         = 0;
  int     n_starts        = 0;
  int     n_sets          = 0;
  int     n_unused        = 0;
  int     n_loads         = 0;
  int     rsp_hold_cycles = 0;
  bit     no_idle         = 1'b0;

  function automatic logic [TIME_BITS-1:0] sat_ms(logic [TIME_BITS-1:0] acc,
                                                  logic [ADV_BITS-1:0] adv);
    logic [TIME_BITS:0] sum;
    sum = acc + adv;
    return sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  endfunction

  // base + num * span / den, rounded to nearest with ties going down
  function automatic logic [VALUE_BITS-1:0] lerp_ms(logic [VALUE_BITS-1:0] base,
                                                    logic [TIME_BITS-1:0] num,
                                                    logic [VALUE_BITS-1:0] span,
                                                    logic [TIME_BITS-1:0] den);
    logic [TIME_BITS+VALUE_BITS-1:0] prod;
    logic [TIME_BITS+VALUE_BITS-1:0] quo;
    logic [TIME_BITS+VALUE_BITS-1:0] rem;
    prod = num * span;
    quo  = prod / den;
    rem  = prod % den;
    if (rem > den - rem) quo++;
    return base + quo[VALUE_BITS-1:0];
  endfunction

  function automatic void rerun();
    an_delaying = 1'b0;
    an_run_ms   = '0;
    an_ramping  = an_ramp_ms != 0;
    an_value    = (an_ramp_ms != 0) ? an_from : an_to;
  endfunction

  function automatic void arm();
    mode_t                 m;
    logic [VALUE_BITS-1:0] b;
    logic [VALUE_BITS-1:0] e;
    logic [TIME_BITS-1:0]  ph;
    logic [TIME_BITS-1:0]  du;
    m  = cfg_q[REG_MODE][MODE_BITS-1:0];
    b  = cfg_q[REG_BEGIN][VALUE_BITS-1:0];
    e  = cfg_q[REG_END][VALUE_BITS-1:0];
    ph = cfg_q[REG_PHASE][TIME_BITS-1:0];
    du = cfg_q[REG_DURATION][TIME_BITS-1:0];
    an_delaying  = 1'b0;
    an_ramping   = 1'b0;
    an_delay_acc = '0;
    an_run_ms    = '0;
    if (!(m == MODE_RAMP || m == MODE_PINGPONG) || (ph == 0 && du == 0) || b == e) begin
      an_mode  = MODE_NONE;
      an_value = e;
      return;
    end
    an_mode    = m;
    an_from    = b;
    an_to      = e;
    an_hold_ms = cfg_q[REG_DELAY][TIME_BITS-1:0];
    an_ramp_ms = ph;
    an_run_len = (ph > du) ? ph : du;
    an_repeats = cfg_q[REG_REPEAT][REP_BITS-1:0];
    rerun();
    if (an_hold_ms != 0) begin
      an_delaying = 1'b1;
      an_ramping  = 1'b0;
    end
  endfunction

  function automatic void tick(logic [ADV_BITS-1:0] adv);
    logic [TIME_BITS-1:0] den;
    logic [TIME_BITS-1:0] k;
    if (an_mode == MODE_NONE) return;
    if (an_delaying) begin
      an_delay_acc = sat_ms(an_delay_acc, adv);
      if (an_delay_acc < an_hold_ms) return;
      rerun();
    end else begin
      an_run_ms = sat_ms(an_run_ms, adv);
    end
    if (an_run_ms >= an_run_len) begin
      an_value = (an_mode == MODE_PINGPONG && an_ramp_ms != an_run_len) ? an_from : an_to;
      if (an_repeats == 0) begin
        an_mode = MODE_NONE;
        return;
      end
      if (an_repeats != REPEAT_FOREVER) an_repeats--;
      rerun();
      return;
    end
    if (an_ramping) begin
      if (an_run_ms >= an_ramp_ms) begin
        an_ramping = 1'b0;
        an_value   = an_to;
      end else if (an_to > an_from) begin
        an_value = lerp_ms(an_from, an_run_ms, an_to - an_from, an_ramp_ms);
      end else begin
        an_value = lerp_ms(an_to, an_ramp_ms - an_run_ms, an_from - an_to, an_ramp_ms);
      end
    end else if (an_mode == MODE_PINGPONG && an_run_ms >= an_ramp_ms) begin
      den = an_run_len - an_ramp_ms;
      k   = an_run_ms - an_ramp_ms;
      if (den != 0) begin
        if (an_to > an_from) an_value = lerp_ms(an_from, den - k, an_to - an_from, den);
        else an_value = lerp_ms(an_to, k, an_from - an_to, den);
      end
    end
  endfunction

  function automatic frame_t advance_animation(req_t kind, logic [ADV_BITS-1:0] adv,
                                               logic [VALUE_BITS-1:0] val);
    frame_t f;
    case (kind)
      REQ_TICK: begin
        n_ticks++;
        tick(adv);
      end
      REQ_START: begin
        n_starts++;
        arm();
      end
      REQ_SET: begin
        n_sets++;
        an_mode     = MODE_NONE;
        an_delaying = 1'b0;
        an_ramping  = 1'b0;
        an_value    = val;
      end
      default: n_unused++;
    endcase
    f.value   = an_value;
    f.pending = an_mode != MODE_NONE;
    f.holding = f.pending && an_delaying;
    return f;
  endfunction

  task automatic send_word(req_t kind, logic [ADV_BITS-1:0] adv, logic [VALUE_BITS-1:0] val);
    int gap;
    @(negedge clk_i);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.advance_ms <= adv;
    req_ch.new_value  <= val;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    due_frames.push_back(advance_animation(kind, adv, val));
  endtask

  task automatic write_reg(reg_idx_t idx, logic [APB_DATA_BITS-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    cfg_q[idx] = data;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_config(mode_t m, logic [VALUE_BITS-1:0] b, logic [VALUE_BITS-1:0] e,
                             logic [TIME_BITS-1:0] d, logic [TIME_BITS-1:0] ph,
                             logic [TIME_BITS-1:0] du, logic [REP_BITS-1:0] rep);
    write_reg(REG_MODE, APB_DATA_BITS'(m));
    write_reg(REG_BEGIN, APB_DATA_BITS'(b));
    write_reg(REG_END, APB_DATA_BITS'(e));
    write_reg(REG_DELAY, APB_DATA_BITS'(d));
    write_reg(REG_PHASE, APB_DATA_BITS'(ph));
    write_reg(REG_DURATION, APB_DATA_BITS'(du));
    write_reg(REG_REPEAT, APB_DATA_BITS'(rep));
    n_loads++;
  endtask

  // drop valid, drain all outstanding words, then let the block go quiet
  task automatic settle();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (due_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  task automatic load_random_config();
    mode_t                 m;
    logic [TIME_BITS-1:0]  d;
    logic [TIME_BITS-1:0]  ph;
    logic [TIME_BITS-1:0]  du;
    logic [REP_BITS-1:0]   rep;
    if ($urandom_range(0, 9) < 8) m = $urandom_range(0, 1) ? MODE_PINGPONG : MODE_RAMP;
    else m = mode_t'($urandom_range(0, 3));
    d = $urandom_range(0, 1) ? '0 : TIME_BITS'($urandom_range(1, 40));
    case ($urandom_range(0, 9))
      0:       ph = '0;
      1:       ph = TIME_BITS'($urandom);
      default: ph = TIME_BITS'($urandom_range(1, 120));
    endcase
    case ($urandom_range(0, 9))
      0:       du = '0;
      1:       du = TIME_BITS'($urandom);
      2:       du = ph;
      default: du = TIME_BITS'($urandom_range(0, 250));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: rep = '0;
      4, 5, 6, 7: rep = REP_BITS'($urandom_range(1, 4));
      8:          rep = REPEAT_FOREVER;
      default:    rep = REP_BITS'($urandom);
    endcase
    load_config(m, pick_level(), pick_level(), d, ph, du, rep);
  endtask

  task automatic send_random_word();
    int                  r;
    logic [ADV_BITS-1:0] adv;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       adv = ADV_BITS'($urandom);
      1, 2:    adv = ADV_BITS'($urandom_range(0, 400));
      default: adv = ADV_BITS'($urandom_range(0, 25));
    endcase
    if (r < 84) send_word(REQ_TICK, adv, VALUE_BITS'($urandom));
    else if (r < 90) send_word(REQ_START, adv, VALUE_BITS'($urandom));
    else if (r < 96) send_word(REQ_SET, adv, pick_level());
    else send_word(REQ_UNUSED, adv, VALUE_BITS'($urandom));
  endtask

  task automatic test_idle_requests();
    send_word(REQ_TICK, '1, VALUE_BITS'($urandom));
    send_word(REQ_UNUSED, ADV_BITS'($urandom), VALUE_BITS'($urandom));
    send_word(REQ_SET, ADV_BITS'($urandom), 16'hA5A5);
    send_word(REQ_SET, ADV_BITS'($urandom), '0);
    send_word(REQ_START, ADV_BITS'($urandom), VALUE_BITS'($urandom));
  endtask

  task automatic test_degenerate_starts();
    settle();
    load_config(MODE_UNUSED, 16'd1, 16'd2, 24'd0, 24'd10, 24'd10, 16'd0);
    send_word(REQ_START, '0, VALUE_BITS'($urandom));
    settle();
    load_config(MODE_RAMP, 16'd1, 16'd2, 24'd0, 24'd0, 24'd0, 16'd0);
    send_word(REQ_START, '0, VALUE_BITS'($urandom));
    settle();
    load_config(MODE_PINGPONG, 16'd77, 16'd77, 24'd0, 24'd10, 24'd10, 16'd0);
    send_word(REQ_START, '0, VALUE_BITS'($urandom));
    send_word(REQ_TICK, 16'd5, VALUE_BITS'($urandom));
    settle();
    load_config(MODE_NONE, 16'd5, 16'd9, 24'd0, 24'd10, 24'd10, 16'd0);
    send_word(REQ_START, '0, VALUE_BITS'($urandom));
  endtask

  task automatic test_ramp_extremes();
    settle();
    load_config(MODE_RAMP, '0, '1, 24'd0, 24'd3, 24'd5, 16'd0);
    send_word(REQ_START, '0, VALUE_BITS'($urandom));
    send_word(REQ_TICK, 16'd1, VALUE_BITS'($urandom));
    send_word(REQ_TICK, 16'd1, VALUE_BITS'($urandom));
    send_word(REQ_TICK, 16'd1, VALUE_BITS'($urandom));
    send_word(REQ_TICK, 16'd2, VALUE_BITS'($urandom));
  endtask

  // descending by one step over two ms: midpoint is an exact tie
  task automatic test_tie_and_delay();
    settle();
    load_config(MODE_RAMP, '1, 16'hFFFE, 24'd3, 24'd2, 24'd2, 16'd1);
    send_word(REQ_START, '0, VALUE_BITS'($urandom));
    send_word(REQ_TICK, 16'd2, VALUE_BITS'($urandom));
    send_word(REQ_TICK, 16'd5, VALUE_BITS'($urandom));
    send_word(REQ_TICK, 16'd1, VALUE_BITS'($urandom));
    send_word(REQ_TICK, 16'd1, VALUE_BITS'($urandom));
    send_word(REQ_TICK, 16'd3, VALUE_BITS'($urandom));
  endtask

  task automatic test_pingpong_forever();
    settle();
    load_config(MODE_PINGPONG, 16'd10, 16'd1000, 24'd0, 24'd0, 24'd50, REPEAT_FOREVER);
    send_word(REQ_START, '0, VALUE_BITS'($urandom));
    send_word(REQ_TICK, 16'd25, VALUE_BITS'($urandom));
    send_word(REQ_TICK, 16'd30, VALUE_BITS'($urandom));
    send_word(REQ_TICK, 16'd80, VALUE_BITS'($urandom));
    send_word(REQ_UNUSED, ADV_BITS'($urandom), VALUE_BITS'($urandom));
    send_word(REQ_SET, ADV_BITS'($urandom), 16'd7);
  endtask

  task automatic test_output_stall();
    settle();
    load_config(MODE_PINGPONG, '0, '1, 24'd5, 24'd40, 24'd100, REPEAT_FOREVER);
    rsp_hold_cycles = HOLD_CYCLES;
    send_word(REQ_START, '0, VALUE_BITS'($urandom));
    repeat (15) send_word(REQ_TICK, ADV_BITS'($urandom_range(0, 12)), VALUE_BITS'($urandom));
  endtask

  // full-scale run time: the run counter saturates at all ones and ends the run
  task automatic test_counter_saturation();
    settle();
    load_config(MODE_PINGPONG, '1, '0, 24'd3, '1, '1, 16'd0);
    send_word(REQ_START, '0, VALUE_BITS'($urandom));
    repeat (260) send_word(REQ_TICK, '1, VALUE_BITS'($urandom));
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      if (p == RANDOM_PHASES - 1) no_idle = 1'b1;
      load_random_config();
      send_word(REQ_START, '0, VALUE_BITS'($urandom));
      repeat (WORDS_PER_PHASE) send_random_word();
    end
  endtask

  initial begin : result_sink
    int stall;
    int held;
    stall = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rsp_hold_cycles != 0) begin
        rsp_ch.ready <= 1'b0;
        for (held = 0; held < rsp_hold_cycles; held++) @(negedge clk_i);
        rsp_hold_cycles = 0;
        rsp_ch.ready <= 1'b1;
      end else if (stall != 0) begin
        stall--;
        rsp_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 11) == 0) begin
        stall = $urandom_range(0, 17);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (due_frames.size() == 0) begin
        $error("result word with nothing expected: current_value %0d", rsp_ch.current_value);
        errors++;
      end else begin
        want = due_frames.pop_front();
        n_checked++;
        if (rsp_ch.current_value !== want.value) begin
          $error("current_value: expected %0d, got %0d", want.value, rsp_ch.current_value);
          errors++;
        end
        if (rsp_ch.pending !== want.pending) begin
          $error("pending: expected %0d, got %0d", want.pending, rsp_ch.pending);
          errors++;
        end
        if (rsp_ch.holding_delay !== want.holding) begin
          $error("holding_delay: expected %0d, got %0d", want.holding, rsp_ch.holding_delay);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (psel && penable)) quiet = 0;
      else quiet++;
    end
    $display("tb_linear_value_animator_core failed");
    $finish;
  end

  initial begin
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_TICK;
    req_ch.advance_ms = '0;
    req_ch.new_value  = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_idle_requests();
    test_degenerate_starts();
    test_ramp_extremes();
    test_tie_and_delay();
    test_pingpong_forever();
    test_output_stall();
    test_counter_saturation();
    test_random_phases();
    settle();

    $display("sent %0d request words: %0d ticks, %0d starts, %0d sets, %0d unknown codes",
             n_ticks + n_starts + n_sets + n_unused, n_ticks, n_starts, n_sets, n_unused);
    $display("checked %0d result words over %0d register loads, %0d mismatches",
             n_checked, n_loads, errors);
    if (errors == 0) begin
      $display("tb_linear_value_animator_core passed");
    end else begin
      $display("tb_linear_value_animator_core failed");
    end
    $finish;
  end

endmodule

@@ linear_value_animator_core.f @@
+incdir+rtl
rtl/lva_pkg.sv
rtl/lva_if.sv
rtl/lva_lerp.sv
rtl/linear_value_animator_core.sv
tb/tb_linear_value_animator_core.sv
